// ===== rtl/core/assert_macros.svh =====
// Assertion helpers. Every check is sampled on clk and held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge.
`define CHK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// An implication: when ante is true, cons must also be true.
`define CHK_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/mmci_pkg.sv =====
package mmci_pkg;

  localparam int MATRIX_SIZE = 256;
  localparam int FIELD_PRIME = 127;
  localparam int IDX_W       = 8;
  localparam int COEFF_W     = 7;
  localparam int CMD_W       = 2;
  localparam int TDATA_W     = 24;
  localparam int PROD_W      = 2 * COEFF_W;

  localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_COMPOSE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_INVERT  = 2'd2;

  // Item held between the store read and the result register.
  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [IDX_W-1:0]   index;
    logic [IDX_W-1:0]   perm;
    logic [COEFF_W-1:0] coeff;
    logic [IDX_W-1:0]   rd_perm;
    logic [COEFF_W-1:0] rd_coeff;
  } stage_t;

  typedef struct packed {
    logic [COEFF_W-1:0] coeff;
    logic [IDX_W-1:0]   perm;
    logic [IDX_W-1:0]   position;
  } result_t;

  typedef logic [(1 << COEFF_W)-1:0][COEFF_W-1:0] inv_table_t;

  // Reduction mod 2^COEFF_W - 1 by folding the upper half onto the lower.
  function automatic logic [COEFF_W-1:0] mod_prime(input logic [PROD_W-1:0] x);
    logic [COEFF_W:0] s1;
    logic [COEFF_W:0] s2;
    s1 = {1'b0, x[COEFF_W-1:0]} + {1'b0, x[PROD_W-1:COEFF_W]};
    s2 = {1'b0, s1[COEFF_W-1:0]} + {{COEFF_W{1'b0}}, s1[COEFF_W]};
    if (s2 >= (COEFF_W+1)'(FIELD_PRIME)) begin
      s2 = s2 - (COEFF_W+1)'(FIELD_PRIME);
    end
    return s2[COEFF_W-1:0];
  endfunction

  // a^(p-2) mod p, evaluated at elaboration only.
  function automatic logic [COEFF_W-1:0] inv_calc(input int a);
    int base;
    int acc;
    int e;
    base = a % FIELD_PRIME;
    acc  = 1;
    e    = FIELD_PRIME - 2;
    if (base == 0) begin
      return '0;
    end
    for (int i = 0; i < 32; i++) begin
      if (e[i]) begin
        acc = (acc * base) % FIELD_PRIME;
      end
      base = (base * base) % FIELD_PRIME;
    end
    return COEFF_W'(acc);
  endfunction

  function automatic inv_table_t build_inv_table();
    inv_table_t t;
    for (int i = 0; i < (1 << COEFF_W); i++) begin
      t[i] = inv_calc(i);
    end
    return t;
  endfunction

  localparam inv_table_t INV_TABLE = build_inv_table();

endpackage

// ===== rtl/core/mmci_arith.sv =====
module mmci_arith
  import mmci_pkg::*;
(
  input  stage_t  stage_i,
  output result_t result_o
);

  logic [PROD_W-1:0] prod;

  assign prod = {{COEFF_W{1'b0}}, stage_i.coeff} * {{COEFF_W{1'b0}}, stage_i.rd_coeff};

  always_comb begin
    result_o = '0;
    case (stage_i.cmd)
      CMD_COMPOSE: begin
        result_o.position = stage_i.index;
        result_o.perm     = stage_i.rd_perm;
        result_o.coeff    = mod_prime(prod);
      end
      CMD_INVERT: begin
        result_o.position = stage_i.perm;
        result_o.perm     = stage_i.index;
        result_o.coeff    = INV_TABLE[stage_i.coeff];
      end
      default: begin
        result_o = '0;
      end
    endcase
  end

endmodule

// ===== rtl/core/monomial_matrix_compose_invert_top.sv =====
// Monomial matrix compose / invert over GF(127), one entry per item.
// Input channel in_*: tuser carries the command (load, compose, invert),
// tdata the entry (index, permutation target, coefficient). A load writes
// the second matrix's entry at index into an internal 256-entry store and
// yields no result. A compose reads the store at the entry's target and
// returns the product entry; an invert returns the entry scattered to its
// target with the inverse coefficient. Command 3 is dropped.
// Output channel out_*: tdata carries position, permutation, coefficient.
// An accepted item passes the store read register, then the multiply/fold or
// inverse table into the result register. Throughput is one item per cycle
// while the output is not stalled; loads can be followed by a compose of the
// same entry in the next cycle.
// Reset clears the valid flags only; the store holds garbage until loaded and
// a compose must only target loaded entries.
// When out_tready is low the result holds, one more item waits in the read
// stage, and then in_tready drops until the result is taken.
module monomial_matrix_compose_invert_top
  import mmci_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,   // index, perm_value, coeff_value, zero pad
  input  logic [CMD_W-1:0]   in_tuser,   // command
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata   // position, result_perm, result_coeff, zero pad
);

  logic [IDX_W+COEFF_W-1:0] mem [MATRIX_SIZE];

  logic               in_acc;
  logic [IDX_W-1:0]   in_index;
  logic [IDX_W-1:0]   in_perm;
  logic [COEFF_W-1:0] in_coeff;
  logic               in_result;

  logic    s1_valid_r;
  logic    s1_valid_nxt;
  stage_t  s1_r;
  logic [IDX_W+COEFF_W-1:0] rd_r;
  stage_t  s1_full;
  logic    s1_move;
  logic    out_valid_r;
  logic    out_valid_nxt;
  result_t out_r;
  result_t res;

  assign in_index  = in_tdata[IDX_W-1:0];
  assign in_perm   = in_tdata[2*IDX_W-1:IDX_W];
  assign in_coeff  = in_tdata[2*IDX_W+COEFF_W-1:2*IDX_W];
  assign in_acc    = in_tvalid && in_tready;
  assign in_result = (in_tuser == CMD_COMPOSE) || (in_tuser == CMD_INVERT);

  assign s1_move   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_move;

  always_ff @(posedge clk) begin
    if (in_acc && (in_tuser == CMD_LOAD)) begin
      mem[in_index] <= {in_perm, in_coeff};
    end
    if (in_acc) begin
      rd_r <= mem[in_perm];
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = in_result;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r.cmd      <= in_tuser;
      s1_r.index    <= in_index;
      s1_r.perm     <= in_perm;
      s1_r.coeff    <= in_coeff;
      s1_r.rd_perm  <= '0;
      s1_r.rd_coeff <= '0;
    end
    if (s1_move) begin
      out_r <= res;
    end
  end

  always_comb begin
    s1_full          = s1_r;
    s1_full.rd_perm  = rd_r[IDX_W+COEFF_W-1:COEFF_W];
    s1_full.rd_coeff = rd_r[COEFF_W-1:0];
  end

  mmci_arith u_arith (
    .stage_i  (s1_full),
    .result_o (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(TDATA_W-2*IDX_W-COEFF_W){1'b0}}, out_r.coeff, out_r.perm,
                       out_r.position};

endmodule

// ===== rtl/core/mmci_checker.sv =====
`include "assert_macros.svh"

module mmci_checker
  import mmci_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_tvalid,
  input logic               in_tready,
  input logic [TDATA_W-1:0] in_tdata,
  input logic [CMD_W-1:0]   in_tuser,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [TDATA_W-1:0] out_tdata
);

  // input only backs up when both the read stage and the result are full
  `CHK_IMPL(a_ready_low_full, !in_tready, out_tvalid && !out_tready, "in_tready low, result free")
  // result coefficient is always reduced
  `CHK_IMPL(a_coeff_reduced, out_tvalid, out_tdata[22:16] != 7'd127, "unreduced result coefficient")
  `CHK_ALWAYS(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "result dropped while stalled")
  `CHK_ALWAYS(a_out_stable, out_tvalid && !out_tready |=> $stable(out_tdata), "stalled result changed")

endmodule

bind monomial_matrix_compose_invert_top mmci_checker u_mmci_checker (.*);
